FILE: rtl/ganged_channel_level_adjust_top_macros.svh
// Assertion macros for the ganged channel level adjust block.
// Used by rtl/ganged_channel_level_adjust_top.sv; no other dependencies.
`ifndef GANGED_CHANNEL_LEVEL_ADJUST_TOP_MACROS_SVH
`define GANGED_CHANNEL_LEVEL_ADJUST_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define GCLA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define GCLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GCLA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define GCLA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/gcla_pkg.sv
// Shared constants, codes and helper functions of the ganged channel level adjust block.
// No dependencies; used by rtl/ganged_channel_level_adjust_top.sv.
package gcla_pkg;

    localparam int LEVEL_W          = 7;
    localparam int LEVEL_MAX        = 127;
    localparam int CHAN_W           = 4;
    localparam int COUNT_W          = 5;
    localparam int MODE_W           = 2;
    localparam int SUM_W            = 11;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int S_DATA_W         = 16;
    localparam int M_DATA_W         = 16;

    // Register indexes (word addresses on the APB port).
    localparam logic REG_MIXING_MODE   = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    // Mixing mode register codes.
    localparam logic [MODE_W-1:0] MODE_OVERRIDE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RATIO    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIMARY  = 2'd2;

    // Input function codes.
    localparam logic FUNC_GROUP  = 1'b0;
    localparam logic FUNC_DIRECT = 1'b1;

    // Rule applied to the secondaries during one group change.
    typedef enum logic [1:0] {
        RULE_OVERRIDE = 2'd0,
        RULE_RATIO    = 2'd1,
        RULE_PRIMARY  = 2'd2
    } rule_t;

    // Saturates a signed sum to the level range.
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [SUM_W-1:0] v);
        logic [LEVEL_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > SUM_W'(LEVEL_MAX)) begin
            r = LEVEL_W'(LEVEL_MAX);
        end else begin
            r = v[LEVEL_W-1:0];
        end
        return r;
    endfunction

    // Zero-extends a level into the signed sum width.
    function automatic logic signed [SUM_W-1:0] to_sum(input logic [LEVEL_W-1:0] v);
        return $signed({{(SUM_W-LEVEL_W){1'b0}}, v});
    endfunction

endpackage

FILE: rtl/ganged_channel_level_adjust_top.sv
// Top level of the ganged channel level adjust block: sequencer, level memory, ports.
// Depends on rtl/gcla_pkg.sv and rtl/ganged_channel_level_adjust_top_macros.svh.
//
// This block keeps a 7-bit level for each mixer channel and reports every level an input
// transaction touches. A direct write (func 1) stores one channel's level and returns one
// result transaction; an index at or beyond MAX_CHANNELS is dropped without a result. A
// group change (func 0) sets the primary channel 0 and treats channels 1 .. n-1 by the
// mixing mode, n being channel_count saturated to 1 .. DEPTH, then returns one result per
// group channel, primary first, with tlast on the final one. The levels live in a small
// memory with one write port and one registered read port, and the sequencer walks it one
// channel per cycle while the result channel is not stalled: override and primary-only
// changes run only the update walk, a ratio shift runs a bound-check walk, works out the
// pulled-back delta in ST_CALC, then runs the update walk. The input is not ready while a
// change is in progress. A stalled result channel holds the update walk where it stands. Reset
// clears the per-channel valid bits at once, so no clearing pass is needed after reset.
// Configuration writes on the APB port are applied at once. The mode and the group size are
// sampled when an input transaction is accepted, so they should be written while idle.
`include "ganged_channel_level_adjust_top_macros.svh"

module ganged_channel_level_adjust_top #(
    parameter int MAX_CHANNELS = gcla_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input transactions.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] channel_index, [10:4] proposed_level, [11] force_override, [15:12] zero
    input  logic [gcla_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] func
    input  logic                              s_tuser,
    // Result transactions.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] out_channel, [10:4] out_level, [15:11] zero
    output logic [gcla_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gcla_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gcla_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gcla_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // Only channels 0..15 can ever be addressed, so the memory holds at most 16 entries.
    localparam int DEPTH = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LW    = gcla_pkg::LEVEL_W;
    localparam int SW    = gcla_pkg::SUM_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_CALC = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_ONE  = 5'b10000
    } state_t;

    // Control state.
    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                ptr_reg, ptr_next;
    logic                            pend_reg, pend_next;
    logic [CNT_W-1:0]                n_reg, n_next;
    logic                            m_tvalid_reg;
    logic [gcla_pkg::MODE_W-1:0]     mode_reg;
    logic [gcla_pkg::COUNT_W-1:0]    count_reg;
    logic [DEPTH-1:0]                valid_reg;

    // Payload state.
    gcla_pkg::rule_t                 rule_reg;
    logic [IDX_W-1:0]                cur_reg;
    logic [gcla_pkg::CHAN_W-1:0]     idx_reg;
    logic [LW-1:0]                   prop_reg;
    logic [LW-1:0]                   pri_old_reg;
    logic [LW-1:0]                   min_reg;
    logic [LW-1:0]                   max_reg;
    logic [LW-1:0]                   primary_reg;
    logic signed [SW-1:0]            total_reg;
    logic [LW-1:0]                   rd_data_reg;
    logic                            rd_valid_reg;
    logic [gcla_pkg::CHAN_W-1:0]     m_chan_reg;
    logic [LW-1:0]                   m_level_reg;
    logic                            m_last_reg;

    logic [LW-1:0]                   mem [DEPTH];

    // Input field views.
    logic [gcla_pkg::CHAN_W-1:0]     in_idx;
    logic [LW-1:0]                   in_prop;
    logic                            in_force;
    logic                            in_accept;
    logic [CNT_W-1:0]                n_sat;

    // Walk control.
    logic                            out_free;
    logic                            in_walk;
    logic                            consume;
    logic                            issue;
    logic                            walk_end;
    logic [LW-1:0]                   lvl_rd;
    logic [LW-1:0]                   new_level;

    // Ratio arithmetic.
    logic signed [SW-1:0]            delta;
    logic signed [SW-1:0]            lo_r;
    logic signed [SW-1:0]            hi_r;
    logic signed [SW-1:0]            adjust;
    logic                            has_sec;

    // Memory write / result load.
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [LW-1:0]                   wr_data;
    logic                            wr_last;
    logic                            cfg_wr;

    assign in_idx   = s_tdata[3:0];
    assign in_prop  = s_tdata[10:4];
    assign in_force = s_tdata[11];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(gcla_pkg::M_DATA_W - gcla_pkg::CHAN_W - LW){1'b0}}, m_level_reg,
                       m_chan_reg};
    assign m_tlast  = m_last_reg;

    // APB: two word registers selected by paddr[2]; pready is tied high.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == gcla_pkg::REG_CHANNEL_COUNT) begin
            prdata = gcla_pkg::APB_DATA_W'(count_reg);
        end else begin
            prdata = gcla_pkg::APB_DATA_W'(mode_reg);
        end
    end

    // Group size, saturated to 1 .. DEPTH.
    always_comb begin
        if (count_reg == '0) begin
            n_sat = CNT_W'(1);
        end else if (32'(count_reg) > DEPTH) begin
            n_sat = CNT_W'(DEPTH);
        end else begin
            n_sat = CNT_W'(count_reg);
        end
    end

    // The walk reads one entry ahead of the entry being used; a new read is issued only when no
    // read data is held or the held data is being used this cycle, so a stall never loses a read.
    always_comb begin
        out_free = !m_tvalid_reg || m_tready;
        in_walk  = (state_reg == ST_SCAN) || (state_reg == ST_EMIT);
        consume  = pend_reg && ((state_reg == ST_SCAN) || ((state_reg == ST_EMIT) && out_free));
        issue    = in_walk && (ptr_reg < n_reg) && (!pend_reg || consume);
        walk_end = consume && (CNT_W'(cur_reg) == (n_reg - CNT_W'(1)));
        lvl_rd   = rd_valid_reg ? rd_data_reg : '0;
    end

    // Level written back for the channel under the update walk.
    always_comb begin
        if (cur_reg == '0) begin
            new_level = primary_reg;
        end else if (rule_reg == gcla_pkg::RULE_OVERRIDE) begin
            new_level = prop_reg;
        end else begin
            new_level = gcla_pkg::clamp_level(gcla_pkg::to_sum(lvl_rd) + total_reg);
        end
    end

    // Pull-back of the ratio delta so that no secondary leaves the level range.
    always_comb begin
        has_sec = (n_reg > CNT_W'(1));
        delta   = gcla_pkg::to_sum(prop_reg) - gcla_pkg::to_sum(pri_old_reg);
        lo_r    = gcla_pkg::to_sum(min_reg) + delta;
        hi_r    = gcla_pkg::to_sum(max_reg) + delta;
        if (has_sec && (lo_r < 0)) begin
            adjust = -lo_r;
        end else if (has_sec && (hi_r > SW'(gcla_pkg::LEVEL_MAX))) begin
            adjust = SW'(gcla_pkg::LEVEL_MAX) - hi_r;
        end else begin
            adjust = '0;
        end
    end

    always_comb begin
        if (state_reg == ST_ONE) begin
            wr_en   = out_free;
            wr_addr = idx_reg[IDX_W-1:0];
            wr_data = prop_reg;
            wr_last = 1'b1;
        end else begin
            wr_en   = (state_reg == ST_EMIT) && consume;
            wr_addr = cur_reg;
            wr_data = new_level;
            wr_last = walk_end;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        pend_next  = pend_reg;
        n_next     = n_reg;
        if (issue) begin
            ptr_next  = ptr_reg + CNT_W'(1);
            pend_next = 1'b1;
        end else if (consume) begin
            pend_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    if (s_tuser == gcla_pkg::FUNC_DIRECT) begin
                        if (32'(in_idx) < MAX_CHANNELS) begin
                            state_next = ST_ONE;
                        end
                    end else begin
                        n_next = n_sat;
                        if (!in_force && (mode_reg == gcla_pkg::MODE_RATIO)) begin
                            state_next = ST_SCAN;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (walk_end) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                ptr_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (walk_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= '0;
            pend_reg     <= 1'b0;
            n_reg        <= CNT_W'(1);
            m_tvalid_reg <= 1'b0;
            mode_reg     <= gcla_pkg::MODE_OVERRIDE;
            count_reg    <= gcla_pkg::COUNT_W'(1);
            valid_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            n_reg     <= n_next;
            if (wr_en) begin
                m_tvalid_reg       <= 1'b1;
                valid_reg[wr_addr] <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[2] == gcla_pkg::REG_CHANNEL_COUNT) begin
                    count_reg <= pwdata[gcla_pkg::COUNT_W-1:0];
                end else begin
                    mode_reg <= pwdata[gcla_pkg::MODE_W-1:0];
                end
            end
        end
    end

    // Level memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg  <= mem[ptr_reg[IDX_W-1:0]];
            rd_valid_reg <= valid_reg[ptr_reg[IDX_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            idx_reg     <= in_idx;
            prop_reg    <= in_prop;
            primary_reg <= in_prop;
            total_reg   <= '0;
            min_reg     <= LW'(gcla_pkg::LEVEL_MAX);
            max_reg     <= '0;
            if (in_force || (mode_reg == gcla_pkg::MODE_OVERRIDE)) begin
                rule_reg <= gcla_pkg::RULE_OVERRIDE;
            end else if (mode_reg == gcla_pkg::MODE_RATIO) begin
                rule_reg <= gcla_pkg::RULE_RATIO;
            end else begin
                rule_reg <= gcla_pkg::RULE_PRIMARY;
            end
        end
        if (issue) begin
            cur_reg <= ptr_reg[IDX_W-1:0];
        end
        if ((state_reg == ST_SCAN) && consume) begin
            if (cur_reg == '0) begin
                pri_old_reg <= lvl_rd;
            end else begin
                if (lvl_rd < min_reg) begin
                    min_reg <= lvl_rd;
                end
                if (lvl_rd > max_reg) begin
                    max_reg <= lvl_rd;
                end
            end
        end
        if (state_reg == ST_CALC) begin
            total_reg   <= delta + adjust;
            primary_reg <= gcla_pkg::clamp_level(gcla_pkg::to_sum(prop_reg) + adjust);
        end
        if (wr_en) begin
            m_chan_reg  <= gcla_pkg::CHAN_W'(wr_addr);
            m_level_reg <= wr_data;
            m_last_reg  <= wr_last;
        end
    end

    // The walk pointer never runs past the group size.
    `GCLA_ASSERT_IMPLIES(a_ptr_in_group, aclk, aresetn, in_walk, ptr_reg <= n_reg)
    // Read data is only held while a walk is in progress.
    `GCLA_ASSERT_IMPLIES(a_pend_in_walk, aclk, aresetn, pend_reg, in_walk)
    // An accepted group change always leaves the block busy in the next cycle.
    `GCLA_ASSERT_NEXT(a_group_busy, aclk, aresetn,
        in_accept && (s_tuser == gcla_pkg::FUNC_GROUP), state_reg != ST_IDLE)
    // Loading the final result of a transaction returns the sequencer to idle.
    `GCLA_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, wr_en && wr_last, state_reg == ST_IDLE)

endmodule
